### hdl/dtsc_pkg.sv
package dtsc_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int RECORD_WIDTH = 16;
    localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EPOCH_W      = 8;
    localparam int MODE_W       = 2;
    localparam int KEY_W        = 10;
    localparam int REC_PORT_W   = 16;
    localparam int STATUS_W     = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_STORE     = 2'd0,
        MODE_CHECK     = 2'd1,
        MODE_CHECK_REC = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_MATCH   = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_DIFFERS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic store_wr;
        logic check_rd;
        logic check_done;
        logic sweep_wr;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic epoch_max;
        logic sweep_end;
    } stat_t;

endpackage

### hdl/dtsc_ctrl.sv
module dtsc_ctrl
    import dtsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  stat_t             st,
    output logic              busy,
    output cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;
    logic   is_check;

    assign is_check = (mode == MODE_CHECK) || (mode == MODE_CHECK_REC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && is_check)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.last && st.epoch_max)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (st.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy         = 1'b0;
                cmd.store_wr = start && (mode == MODE_STORE);
                cmd.check_rd = start && is_check;
            end
            S_CHECK:
            begin
                cmd.check_done = 1'b1;
            end
            S_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### hdl/dtsc_dp.sv
module dtsc_dp
    import dtsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [MODE_W-1:0]     mode,
    input  logic [KEY_W-1:0]      key,
    input  logic [REC_PORT_W-1:0] record,
    input  logic                  last,
    output stat_t                 st,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [KEY_W-1:0]      key_out,
    output logic [REC_PORT_W-1:0] stored_record,
    output logic                  all_present,
    output logic                  pass_end
);

    localparam int WORD_W = EPOCH_W + RECORD_WIDTH;

    // entry = {epoch tag, record}; an entry is valid only when its tag matches epoch_reg
    logic [WORD_W-1:0]       mem [TABLE_DEPTH];

    logic [ADDR_W-1:0]       key_addr;
    logic                    key_in_range;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;

    logic [ADDR_W-1:0]       sweep_idx_reg;
    logic [EPOCH_W-1:0]      epoch_reg;
    logic                    all_found_reg;
    logic                    all_found_next;

    logic [WORD_W-1:0]       rd_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [RECORD_WIDTH-1:0] rec_reg;
    logic                    last_reg;
    logic                    in_range_reg;

    logic                    hit;
    logic [RECORD_WIDTH-1:0] held_next;
    status_t                 status_next;

    logic                    done_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [KEY_W-1:0]        key_out_reg;
    logic [REC_PORT_W-1:0]   stored_record_reg;
    logic                    all_present_reg;
    logic                    pass_end_reg;

    assign key_addr     = ADDR_W'(key);
    assign key_in_range = (32'(key) < 32'(TABLE_DEPTH));

    assign mem_we    = (cmd.store_wr && key_in_range) || cmd.sweep_wr;
    assign mem_waddr = cmd.sweep_wr ? sweep_idx_reg : key_addr;
    assign mem_wdata = cmd.sweep_wr ? '0 : {epoch_reg, record[RECORD_WIDTH-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check_rd)
        begin
            rd_reg       <= mem[key_addr];
            mode_reg     <= mode;
            key_reg      <= key;
            rec_reg      <= record[RECORD_WIDTH-1:0];
            last_reg     <= last;
            in_range_reg <= key_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_idx_reg <= sweep_idx_reg + ADDR_W'(1);
        end
        else
        begin
            sweep_idx_reg <= '0;
        end
    end

    assign st.sweep_end = (sweep_idx_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign st.epoch_max = (epoch_reg == '1);
    assign st.last      = last_reg;

    // epoch zero is what the sweep writes, so it never counts as live
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_W'(1);
        end
        else if (cmd.sweep_wr && st.sweep_end)
        begin
            epoch_reg <= EPOCH_W'(1);
        end
        else if (cmd.check_done && last_reg && !st.epoch_max)
        begin
            epoch_reg <= epoch_reg + EPOCH_W'(1);
        end
    end

    assign hit       = in_range_reg && (rd_reg[WORD_W-1:RECORD_WIDTH] == epoch_reg);
    assign held_next = hit ? rd_reg[RECORD_WIDTH-1:0] : '0;

    always_comb
    begin
        priority if (!hit)
        begin
            status_next = STAT_MISSING;
        end
        else if ((mode_reg == MODE_CHECK_REC) && (held_next != rec_reg))
        begin
            status_next = STAT_DIFFERS;
        end
        else
        begin
            status_next = STAT_MATCH;
        end
    end

    assign all_found_next = hit && all_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_found_reg <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.check_done;
            if (cmd.check_done)
            begin
                all_found_reg <= last_reg ? 1'b1 : all_found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check_done)
        begin
            status_reg        <= status_next;
            key_out_reg       <= key_reg;
            stored_record_reg <= REC_PORT_W'(held_next);
            all_present_reg   <= all_found_next;
            pass_end_reg      <= last_reg;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign key_out       = key_out_reg;
    assign stored_record = stored_record_reg;
    assign all_present   = all_present_reg;
    assign pass_end      = pass_end_reg;

endmodule

### hdl/direct_table_set_compare.sv
// Store beat: written at the accepting edge, no result; next beat may follow in the next cycle.
// Check beat: the table read is registered at acceptance, the result is registered from it and
// strobed on done; busy is high meanwhile, so a new check waits until the current one is through.
// Reset (async, rst_n low) starts a clearing pass over all TABLE_DEPTH (1024) entries with busy high.
// The same pass follows the check that ends every 255th pass, when the 8-bit epoch tag wraps.
// Results cannot be stalled: each is on the ports for exactly one cycle.
module direct_table_set_compare
    import dtsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     mode,
    input  logic [KEY_W-1:0]      key,
    input  logic [REC_PORT_W-1:0] record,
    input  logic                  last,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [KEY_W-1:0]      key_out,
    output logic [REC_PORT_W-1:0] stored_record,
    output logic                  all_present,
    output logic                  pass_end
);

    cmd_t  cmd;
    stat_t st;

    dtsc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .st    (st),
        .busy  (busy),
        .cmd   (cmd)
    );

    dtsc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .key           (key),
        .record        (record),
        .last          (last),
        .st            (st),
        .done          (done),
        .status        (status),
        .key_out       (key_out),
        .stored_record (stored_record),
        .all_present   (all_present),
        .pass_end      (pass_end)
    );

    a_check_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((mode == MODE_CHECK) || (mode == MODE_CHECK_REC)))
        |=> busy ##1 done)
        else $error("check beat did not produce a result");

    a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_STORE)) |=> (!busy && !done))
        else $error("store beat stalled or produced a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a lookup cycle");

    a_missing_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_MISSING)) |-> (!all_present && (stored_record == '0)))
        else $error("missing key reported as present");

endmodule

### dv/direct_table_set_compare_tb.sv
`timescale 1ns / 100ps

module direct_table_set_compare_tb;
    import dtsc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [REC_PORT_W-1:0] REC_MASK = REC_PORT_W'((64'd1 << RECORD_WIDTH) - 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 1380;

    typedef struct {
        status_t                status;
        logic [KEY_W-1:0]       key;
        logic [REC_PORT_W-1:0]  rec;
        logic                   all_present;
        logic                   pass_end;
    } lookup_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [MODE_W-1:0]     mode = '0;
    logic [KEY_W-1:0]      key = '0;
    logic [REC_PORT_W-1:0] record = '0;
    logic                  last = 1'b0;
    logic                  busy;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [KEY_W-1:0]      key_out;
    logic [REC_PORT_W-1:0] stored_record;
    logic                  all_present;
    logic                  pass_end;

    // shadow of the table
    logic [REC_PORT_W-1:0] shadow_rec [TABLE_DEPTH];
    logic                  shadow_valid [TABLE_DEPTH];
    logic                  shadow_all_found;
    lookup_t               pending_lookups [$];

    bit steady;
    int n_beats;
    int n_checked;
    int n_passes;
    int n_missing;
    int n_differs;
    int n_errors;
    int cycles;

    direct_table_set_compare u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .key           (key),
        .record        (record),
        .last          (last),
        .done          (done),
        .status        (status),
        .key_out       (key_out),
        .stored_record (stored_record),
        .all_present   (all_present),
        .pass_end      (pass_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void predict_lookup(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                                           logic [REC_PORT_W-1:0] r, logic l);
        lookup_t                exp;
        logic [REC_PORT_W-1:0]  rm;
        bit                     hit;
        rm = r & REC_MASK;
        if (m == MODE_STORE)
        begin
            if (int'(k) < TABLE_DEPTH)
            begin
                shadow_rec[k]   = rm;
                shadow_valid[k] = 1'b1;
            end
            return;
        end
        if (m == MODE_UNUSED)
            return;
        hit = (int'(k) < TABLE_DEPTH) && shadow_valid[k];
        exp.key      = k;
        exp.pass_end = l;
        if (!hit)
        begin
            exp.status       = STAT_MISSING;
            exp.rec          = '0;
            shadow_all_found = 1'b0;
            n_missing++;
        end
        else
        begin
            exp.rec = shadow_rec[k];
            if (m == MODE_CHECK_REC && shadow_rec[k] != rm)
            begin
                exp.status = STAT_DIFFERS;
                n_differs++;
            end
            else
                exp.status = STAT_MATCH;
        end
        exp.all_present = shadow_all_found;
        pending_lookups.push_back(exp);
        if (l)
        begin
            foreach (shadow_valid[i])
                shadow_valid[i] = 1'b0;
            shadow_all_found = 1'b1;
            n_passes++;
        end
    endfunction

    task automatic idle_gap();
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_beat(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                             logic [REC_PORT_W-1:0] r, logic l);
        start  <= 1'b1;
        mode   <= m;
        key    <= k;
        record <= r;
        last   <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_lookup(m, k, r, l);
        if (m != MODE_UNUSED)
            n_beats++;
        idle_gap();
    endtask

    task automatic drain_lookups();
        start <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [REC_PORT_W-1:0] rand_record();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return REC_PORT_W'($urandom);
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        lookup_t exp;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual key %0h status %0d",
                         $time, key_out, status);
                n_errors++;
            end
            else
            begin
                exp = pending_lookups.pop_front();
                check_field("status", exp.status, status);
                check_field("key_out", exp.key, key_out);
                check_field("stored_record", exp.rec, stored_record);
                check_field("all_present", exp.all_present, all_present);
                check_field("pass_end", exp.pass_end, pass_end);
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_lookups.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed_lookups();
        send_beat(MODE_STORE,     10'd0,    16'h0000, 1'b0);
        send_beat(MODE_STORE,     10'd1023, 16'hFFFF, 1'b0);
        send_beat(MODE_STORE,     10'h155,  16'h1234, 1'b0);
        send_beat(MODE_STORE,     10'h155,  16'hABCD, 1'b0);
        send_beat(MODE_STORE,     10'h2AA,  16'h5555, 1'b1);
        send_beat(MODE_UNUSED,    10'd7,    16'h7777, 1'b1);
        send_beat(MODE_CHECK,     10'd0,    16'hFFFF, 1'b0);
        send_beat(MODE_CHECK_REC, 10'd0,    16'h0000, 1'b0);
        send_beat(MODE_CHECK_REC, 10'd1023, 16'hFFFF, 1'b0);
        send_beat(MODE_CHECK_REC, 10'h155,  16'h1234, 1'b0);
        send_beat(MODE_CHECK_REC, 10'h2AA,  16'hAAAA, 1'b0);
        send_beat(MODE_CHECK,     10'd7,    16'h0000, 1'b0);
        send_beat(MODE_CHECK_REC, 10'd512,  16'hFFFF, 1'b0);
        send_beat(MODE_CHECK,     10'd1023, 16'h0000, 1'b1);
    endtask

    task automatic test_pass_boundaries();
        send_beat(MODE_CHECK_REC, 10'd0,   16'h0000, 1'b1);
        send_beat(MODE_STORE,     10'h3C3, 16'h8001, 1'b0);
        send_beat(MODE_CHECK_REC, 10'h3C3, 16'h8001, 1'b0);
        send_beat(MODE_CHECK,     10'h3C3, 16'h0000, 1'b1);
        send_beat(MODE_UNUSED,    10'h3FF, 16'hFFFF, 1'b0);
        send_beat(MODE_CHECK,     10'h3C3, 16'h0000, 1'b1);
    endtask

    // short passes so the pass count runs well past the epoch wrap
    task automatic test_random_passes(int n_target);
        logic [KEY_W-1:0]      pass_keys [$];
        logic [KEY_W-1:0]      prev_keys [$];
        logic [KEY_W-1:0]      k;
        logic [MODE_W-1:0]     m;
        logic [REC_PORT_W-1:0] r;
        int                    n_start;
        int                    n_store;
        int                    n_look;
        int                    sel;
        bit                    close_pass;
        n_start = n_beats;
        while (n_beats - n_start < n_target)
        begin
            steady = (n_beats - n_start >= 400) && (n_beats - n_start < 700);
            n_store = $urandom_range(0, 3);
            for (int i = 0; i < n_store; i++)
            begin
                if (pass_keys.size() != 0 && $urandom_range(0, 99) < 30)
                    k = pass_keys[$urandom_range(0, pass_keys.size() - 1)];
                else
                    k = KEY_W'($urandom);
                pass_keys.push_back(k);
                send_beat(MODE_STORE, k, rand_record(), $urandom_range(0, 9) == 0);
            end
            if ($urandom_range(0, 99) < 8)
                send_beat(MODE_UNUSED, KEY_W'($urandom), REC_PORT_W'($urandom),
                          1'($urandom));
            n_look = $urandom_range(1, 3);
            close_pass = $urandom_range(0, 9) != 0;
            for (int i = 0; i < n_look; i++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    k = KEY_W'($urandom);
                    pass_keys.push_back(k);
                    send_beat(MODE_STORE, k, rand_record(), 1'b0);
                end
                sel = $urandom_range(0, 99);
                if (pass_keys.size() != 0 && sel < 65)
                    k = pass_keys[$urandom_range(0, pass_keys.size() - 1)];
                else if (prev_keys.size() != 0 && sel < 80)
                    k = prev_keys[$urandom_range(0, prev_keys.size() - 1)];
                else
                    k = KEY_W'($urandom);
                m = $urandom_range(0, 1) ? MODE_CHECK_REC : MODE_CHECK;
                if (shadow_valid[k] && $urandom_range(0, 1))
                    r = shadow_rec[k];
                else
                    r = rand_record();
                send_beat(m, k, r, close_pass && (i == n_look - 1));
            end
            if (close_pass)
            begin
                prev_keys = pass_keys;
                pass_keys.delete();
            end
            if ($urandom_range(0, 99) < 3)
                drain_lookups();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int wait_cycles;
        shadow_all_found = 1'b1;
        foreach (shadow_valid[i])
            shadow_valid[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lookups();
        drain_lookups();
        test_pass_boundaries();
        drain_lookups();
        test_random_passes(RANDOM_BEATS);

        start <= 1'b0;
        wait_cycles = 0;
        while (pending_lookups.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (pending_lookups.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_lookups.size());
            n_errors++;
        end

        $display("ran %0d beats over %0d closed passes; %0d lookups compared", n_beats,
                 n_passes, n_checked);
        $display("lookups by outcome: %0d missing, %0d record differs, %0d mismatches",
                 n_missing, n_differs, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/dtsc_pkg.sv
hdl/dtsc_ctrl.sv
hdl/dtsc_dp.sv
hdl/direct_table_set_compare.sv
dv/direct_table_set_compare_tb.sv
